[hw/rtl/xmtp_pkg.sv]
// Shared constants, types and generator step function for the xorshift test pattern engine.
package xmtp_pkg;

   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 16;
   localparam int NUM_SEEDS = 4;
   localparam int SEED_IDX_W = $clog2(NUM_SEEDS);
   localparam int CSR_ADDR_W = SEED_IDX_W + 2;

   // xorshift128 shift amounts
   localparam int SHIFT_A = 11;
   localparam int SHIFT_B = 8;
   localparam int SHIFT_C = 19;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   // item operation codes
   typedef enum logic [0:0] {
      OP_FILL  = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   // generator words, w[0] is the newest
   typedef struct packed {
      word_type w3;
      word_type w2;
      word_type w1;
      word_type w0;
   } gen_state_type;

   // result of one generator step
   typedef struct packed {
      gen_state_type state;
      word_type      pattern;
   } gen_step_type;

   // advance xorshift128 once
   function automatic gen_step_type gen_advance(input gen_state_type cur);
      word_type     t;
      word_type     s;
      gen_step_type res;
      t = cur.w3;
      s = cur.w0;
      t = t ^ (t << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ s ^ (s >> SHIFT_C);
      res.state.w3 = cur.w2;
      res.state.w2 = cur.w1;
      res.state.w1 = s;
      res.state.w0 = t;
      res.pattern  = t;
      return res;
   endfunction

endpackage

[hw/rtl/xorshift_memory_test_pattern.sv]
// Top level: xorshift128 memory fill pattern generator and readback checker.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle unless rsp_ stalls; the generator step and
//   compare sit between the input register and the result register.
// Reset: synchronous, active high; clears seeds, generator, chunk flag,
//   chunk counter and both valid bits. No clearing pass.
module xorshift_memory_test_pattern (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic                          req_restart,
   input  logic                          req_chunk_start,
   input  xmtp_pkg::word_type            req_mem_word,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output xmtp_pkg::word_type            rsp_pattern_word,
   output xmtp_pkg::word_type            rsp_diff_word,
   output logic                          rsp_word_error,
   output logic                          rsp_chunk_error,
   output xmtp_pkg::count_type           rsp_chunk_count,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [xmtp_pkg::CSR_ADDR_W-1:0] paddr,
   input  xmtp_pkg::word_type            pwdata,
   output xmtp_pkg::word_type            prdata,
   output logic                          pready
);
   import xmtp_pkg::*;

   // seed registers
   word_type      seed_ff [NUM_SEEDS];
   logic [SEED_IDX_W-1:0] csr_idx;
   logic          csr_wr;

   // input register
   logic          s1_valid_ff;
   logic          s1_op_ff;
   logic          s1_restart_ff;
   logic          s1_cstart_ff;
   word_type      s1_mem_ff;

   // block state
   gen_state_type gen_ff;
   gen_state_type gen_in;
   logic          flag_ff;
   logic          flag_in;
   count_type     cnt_ff;
   count_type     cnt_in;

   // result register
   logic          out_valid_ff;
   word_type      out_pattern_ff;
   word_type      out_diff_ff;
   logic          out_werr_ff;
   logic          out_cerr_ff;
   count_type     out_cnt_ff;

   // work terms
   logic          advance;
   logic          is_check;
   gen_state_type gen_src;
   gen_step_type  step;
   word_type      diff;
   logic          werr;
   count_type     cnt_base;
   logic          flag_base;
   word_type      pattern;

   // configuration access
   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite & pready;
   assign prdata  = seed_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEEDS; i++) begin
            seed_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         seed_ff[csr_idx] <= pwdata;
      end
   end

   // handshake: stage 1 moves on when the result register is free or drains
   assign advance   = s1_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;

   // generator step and compare
   assign is_check = (s1_op_ff == OP_CHECK);

   always_comb begin
      gen_src.w0 = s1_restart_ff ? seed_ff[0] : gen_ff.w0;
      gen_src.w1 = s1_restart_ff ? seed_ff[1] : gen_ff.w1;
      gen_src.w2 = s1_restart_ff ? seed_ff[2] : gen_ff.w2;
      gen_src.w3 = s1_restart_ff ? seed_ff[3] : gen_ff.w3;
      step       = gen_advance(gen_src);
      pattern    = step.pattern;
      gen_in     = step.state;

      // little-endian byte lanes line up, so the lane XOR is the word XOR
      diff = is_check ? (s1_mem_ff ^ pattern) : '0;
      werr = (diff != '0);

      // restart on a check clears the counter, then chunk start bumps it
      cnt_base  = (is_check & s1_restart_ff) ? '0 : cnt_ff;
      flag_base = flag_ff;
      if (is_check & s1_cstart_ff) begin
         cnt_base  = cnt_base + 1'b1;
         flag_base = 1'b0;
      end
      cnt_in  = cnt_base;
      flag_in = flag_base | werr;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready & req_valid) begin
         s1_op_ff      <= req_op;
         s1_restart_ff <= req_restart;
         s1_cstart_ff  <= req_chunk_start;
         s1_mem_ff     <= req_mem_word;
      end
   end

   // state update, once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= '0;
         flag_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (advance) begin
         gen_ff  <= gen_in;
         flag_ff <= flag_in;
         cnt_ff  <= cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) begin
         out_pattern_ff <= pattern;
         out_diff_ff    <= diff;
         out_werr_ff    <= werr;
         out_cerr_ff    <= flag_in;
         out_cnt_ff     <= cnt_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pattern_word = out_pattern_ff;
   assign rsp_diff_word    = out_diff_ff;
   assign rsp_word_error   = out_werr_ff;
   assign rsp_chunk_error  = out_cerr_ff;
   assign rsp_chunk_count  = out_cnt_ff;

   // checks
   a_werr_matches_diff: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word_error == (rsp_diff_word != '0)))
      else $error("word error disagrees with difference word");

   a_werr_sets_chunk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid & rsp_word_error) |-> rsp_chunk_error)
      else $error("mismatch did not set chunk error");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff & ~advance) |=> (s1_valid_ff & $stable(s1_mem_ff)))
      else $error("stalled item lost in input register");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(gen_ff) & $stable(cnt_ff) & $stable(flag_ff)))
      else $error("state changed without an item");

endmodule
